[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The condition must never hold at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[design/dmwtc_pkg.sv]
// Shared types and defaults for the direct-mapped write-through cache.
`timescale 1ns / 1ps

package dmwtc_pkg;

  localparam int DEF_NUM_LINES      = 64;
  localparam int DEF_WORDS_PER_LINE = 8;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_INVAL = 2'd3
  } req_kind_t;

  // One request as it waits between the front queue and the back end.
  typedef struct packed {
    req_kind_t   kind;
    logic [31:0] address;
    logic [31:0] data;
    logic        fill_last;
  } req_t;

  // One result as it waits in the result queue.
  typedef struct packed {
    logic        cpu_resp_valid;
    logic [31:0] cpu_read_data;
    logic        hit;
    logic        cpu_ready;
    logic        refill_req_valid;
    logic [31:0] refill_req_address;
    logic        through_write_valid;
    logic [31:0] through_write_address;
    logic [31:0] through_write_data;
  } res_t;

endpackage

[design/dmwtc_front.sv]
// Front end: classifies incoming requests and queues them for the back end.
`timescale 1ns / 1ps

module dmwtc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_req_type,
  input  logic [31:0]        in_address,
  input  logic [31:0]        in_data,
  input  logic               in_fill_last,
  output dmwtc_pkg::req_t    head,
  output logic               head_valid,
  input  logic               head_pop
);

  dmwtc_pkg::req_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_push;
  logic            do_pop;
  dmwtc_pkg::req_t incoming;

  always_comb begin
    incoming.kind      = dmwtc_pkg::req_kind_t'(in_req_type);
    incoming.address   = in_address;
    incoming.data      = in_data;
    incoming.fill_last = in_fill_last;
  end

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/dmwtc_resq.sv]
// Result queue: holds finished results until the receiver pops them.
`timescale 1ns / 1ps

module dmwtc_resq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_push,
  input  dmwtc_pkg::res_t res_in,
  output logic            res_full,
  output logic            empty,
  input  logic            pop,
  output dmwtc_pkg::res_t res_head
);

  dmwtc_pkg::res_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_push;
  logic            do_pop;

  assign res_full = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign res_head = entry_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/dmwtc_back.sv]
// Back end: tag and data memories, miss tracking and result generation.
`timescale 1ns / 1ps

module dmwtc_back #(
  parameter int NUM_LINES      = dmwtc_pkg::DEF_NUM_LINES,
  parameter int WORDS_PER_LINE = dmwtc_pkg::DEF_WORDS_PER_LINE
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dmwtc_pkg::req_t head,
  input  logic            head_valid,
  output logic            head_pop,
  input  logic            res_full,
  output logic            res_push,
  output dmwtc_pkg::res_t res_out
);

  localparam int OFF_BITS = $clog2(WORDS_PER_LINE);
  localparam int IDX_BITS = $clog2(NUM_LINES);
  localparam int SLOT_W   = OFF_BITS + IDX_BITS;
  localparam int TAG_W    = 32 - SLOT_W;
  localparam int DEPTH    = NUM_LINES * WORDS_PER_LINE;
  localparam logic [31:0] BASE_MASK = ~32'(WORDS_PER_LINE - 1);

  typedef enum logic [1:0] {
    S_WAIT,
    S_EXEC,
    S_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CRIT = 2'd1,
    PH_FILL = 2'd2
  } phase_t;

  logic [TAG_W-1:0]  tag_mem  [NUM_LINES];
  logic [31:0]       word_mem [DEPTH];
  logic [NUM_LINES-1:0] valid_r;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [31:0]       miss_address_r, miss_address_nxt;
  logic              miss_is_write_r, miss_is_write_nxt;
  logic [31:0]       miss_write_data_r, miss_write_data_nxt;
  dmwtc_pkg::req_t   req_r;
  logic [TAG_W-1:0]  tag_rd_r;
  logic [31:0]       word_rd_r;

  logic              st_en;
  logic [31:0]       st_addr;
  logic [31:0]       st_data;
  logic              inv_en;
  logic              lookup_hit;
  logic [IDX_BITS-1:0] req_idx;

  assign head_pop   = (state_r == S_WAIT) && head_valid && !res_full;
  assign req_idx    = req_r.address[SLOT_W-1:OFF_BITS];
  assign lookup_hit = valid_r[req_idx] && (tag_rd_r == req_r.address[31:SLOT_W]);

  // Memories are read as a request leaves the queue and written while it
  // executes, so a following request always sees the update.
  always_ff @(posedge clk) begin
    if (head_pop) begin
      tag_rd_r  <= tag_mem[head.address[SLOT_W-1:OFF_BITS]];
      word_rd_r <= word_mem[head.address[SLOT_W-1:0]];
    end
    if (st_en) begin
      tag_mem[st_addr[SLOT_W-1:OFF_BITS]] <= st_addr[31:SLOT_W];
      word_mem[st_addr[SLOT_W-1:0]]       <= st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (st_en) begin
      valid_r[st_addr[SLOT_W-1:OFF_BITS]] <= 1'b1;
    end else if (inv_en) begin
      valid_r[req_idx] <= 1'b0;
    end
  end

  always_comb begin
    state_nxt           = state_r;
    phase_nxt           = phase_r;
    miss_address_nxt    = miss_address_r;
    miss_is_write_nxt   = miss_is_write_r;
    miss_write_data_nxt = miss_write_data_r;
    res_out             = '0;
    res_push            = 1'b0;
    st_en               = 1'b0;
    st_addr             = req_r.address;
    st_data             = req_r.data;
    inv_en              = 1'b0;

    unique case (state_r)
      S_WAIT: begin
        if (head_pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_push  = 1'b1;
        state_nxt = S_WAIT;
        case (req_r.kind)
          dmwtc_pkg::KIND_INVAL: begin
            if (lookup_hit) begin
              inv_en      = 1'b1;
              res_out.hit = 1'b1;
            end
          end
          dmwtc_pkg::KIND_FILL: begin
            if (phase_r == PH_CRIT) begin
              // The critical word lands at the missed address, whatever
              // address the fill carries.
              st_en                  = 1'b1;
              st_addr                = miss_address_r;
              res_out.cpu_resp_valid = 1'b1;
              res_out.cpu_read_data  = req_r.data;
              phase_nxt              = req_r.fill_last ? PH_IDLE : PH_FILL;
            end else if (phase_r == PH_FILL) begin
              st_en = 1'b1;
              if (req_r.fill_last) begin
                phase_nxt = PH_IDLE;
                if (miss_is_write_r) begin
                  res_push  = 1'b0;
                  state_nxt = S_COMMIT;
                end
              end
            end
          end
          default: begin
            if (phase_r == PH_CRIT || phase_r == PH_FILL) begin
              res_out = '0;
            end else if (lookup_hit) begin
              res_out.cpu_resp_valid = 1'b1;
              res_out.hit            = 1'b1;
              if (req_r.kind == dmwtc_pkg::KIND_READ) begin
                res_out.cpu_read_data = word_rd_r;
              end else begin
                st_en                         = 1'b1;
                res_out.through_write_valid   = 1'b1;
                res_out.through_write_address = req_r.address;
                res_out.through_write_data    = req_r.data;
              end
              phase_nxt = PH_IDLE;
            end else begin
              res_out.refill_req_valid = 1'b1;
              miss_address_nxt         = req_r.address;
              if (req_r.kind == dmwtc_pkg::KIND_READ) begin
                res_out.refill_req_address = req_r.address;
                miss_is_write_nxt          = 1'b0;
                phase_nxt                  = PH_CRIT;
              end else begin
                res_out.refill_req_address = req_r.address & BASE_MASK;
                miss_is_write_nxt          = 1'b1;
                miss_write_data_nxt        = req_r.data;
                phase_nxt                  = PH_FILL;
              end
            end
          end
        endcase
        res_out.cpu_ready = (phase_nxt == PH_IDLE);
      end
      S_COMMIT: begin
        // Second store of a write miss: the cpu word goes over the refilled block.
        st_en                         = 1'b1;
        st_addr                       = miss_address_r;
        st_data                       = miss_write_data_r;
        res_push                      = 1'b1;
        res_out.cpu_resp_valid        = 1'b1;
        res_out.cpu_ready             = 1'b1;
        res_out.through_write_valid   = 1'b1;
        res_out.through_write_address = miss_address_r;
        res_out.through_write_data    = miss_write_data_r;
        state_nxt                     = S_WAIT;
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_WAIT;
      phase_r           <= PH_IDLE;
      miss_address_r    <= '0;
      miss_is_write_r   <= 1'b0;
      miss_write_data_r <= '0;
    end else begin
      state_r           <= state_nxt;
      phase_r           <= phase_nxt;
      miss_address_r    <= miss_address_nxt;
      miss_is_write_r   <= miss_is_write_nxt;
      miss_write_data_r <= miss_write_data_nxt;
    end
    if (head_pop) begin
      req_r <= head;
    end
  end

endmodule

[design/direct_mapped_write_through_cache.sv]
// Top level of the direct-mapped write-through write-allocate cache.
// Requests enter through a queue-style port: drive in_req_type, in_address,
// in_data and in_fill_last with push high; a request is taken on an edge where
// full is low. Kinds are cpu read, cpu write, fill word and invalidate.
// Every request produces exactly one result, in request order, on the out_
// ports while empty is low; pop high on such an edge takes it.
// A request is classified and queued by the front end, then the back end reads
// the tag and data memories as it takes the request and updates them in the
// next cycle; it takes no new request until it is through with the last, and
// the last fill word of a write miss adds a commit state for its second memory
// write. With empty queues a result passes through the front queue, the back
// end's request register and the result queue.
// Two requests and two results can wait in the queues, so pushes continue
// while the receiver stalls until both queues are full.
// Reset clears the line valid bits and the miss tracking state; the tag and
// data memories hold no reset value and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module direct_mapped_write_through_cache #(
  parameter int NUM_LINES      = dmwtc_pkg::DEF_NUM_LINES,
  parameter int WORDS_PER_LINE = dmwtc_pkg::DEF_WORDS_PER_LINE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [31:0] in_data,
  input  logic        in_fill_last,
  output logic        empty,
  input  logic        pop,
  output logic        out_cpu_resp_valid,
  output logic [31:0] out_cpu_read_data,
  output logic        out_hit,
  output logic        out_cpu_ready,
  output logic        out_refill_req_valid,
  output logic [31:0] out_refill_req_address,
  output logic        out_through_write_valid,
  output logic [31:0] out_through_write_address,
  output logic [31:0] out_through_write_data
);

  dmwtc_pkg::req_t head;
  logic            head_valid;
  logic            head_pop;
  logic            res_full;
  logic            res_push;
  dmwtc_pkg::res_t res_in;
  dmwtc_pkg::res_t res_head;

  dmwtc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_req_type  (in_req_type),
    .in_address   (in_address),
    .in_data      (in_data),
    .in_fill_last (in_fill_last),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop)
  );

  dmwtc_back #(
    .NUM_LINES      (NUM_LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_out    (res_in)
  );

  dmwtc_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_head (res_head)
  );

  assign out_cpu_resp_valid        = res_head.cpu_resp_valid;
  assign out_cpu_read_data         = res_head.cpu_read_data;
  assign out_hit                   = res_head.hit;
  assign out_cpu_ready             = res_head.cpu_ready;
  assign out_refill_req_valid      = res_head.refill_req_valid;
  assign out_refill_req_address    = res_head.refill_req_address;
  assign out_through_write_valid   = res_head.through_write_valid;
  assign out_through_write_address = res_head.through_write_address;
  assign out_through_write_data    = res_head.through_write_data;

  // A miss leaves a refill pending, so the cache cannot report itself idle.
  `ASSERT_IMPLIES(a_refill_not_ready, clk, rst_n, res_push && res_in.refill_req_valid, !res_in.cpu_ready)
  `ASSERT_NEVER(a_refill_and_through, clk, rst_n, res_push && res_in.refill_req_valid && res_in.through_write_valid)
  `ASSERT_NEVER(a_hit_and_refill, clk, rst_n, res_push && res_in.hit && res_in.refill_req_valid)
  // The back end only finishes a request when the result queue has room.
  `ASSERT_NEVER(a_push_when_full, clk, rst_n, res_push && res_full)

endmodule
